FILE: rtl/text_to_u64_parser_core_defines.svh
// Assertion macros shared by the text to u64 parser RTL.
// Every macro expects clk and rst_n to be in scope where it is used.
`ifndef TEXT_TO_U64_PARSER_CORE_DEFINES_SVH
`define TEXT_TO_U64_PARSER_CORE_DEFINES_SVH

// Combinational or overlapping-implication property, checked outside reset.
`define T2U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define T2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/t2u_pkg.sv
// Package for the text to u64 parser: phase and command types, status and
// result structs, character constants and the digit decoder. No dependencies.
`timescale 1ns / 1ps

package t2u_pkg;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_BLANK,
    PH_ZERO,
    PH_DIGITS,
    PH_SKIP
  } phase_t;

  // Selects the radix that applies to the current character.
  typedef enum logic [2:0] {
    BASE_KEEP,
    BASE_CFG,
    BASE_TEN,
    BASE_OCT,
    BASE_HEX,
    BASE_CLEAR
  } base_sel_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [4:0] NO_DIGIT  = 5'd16;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;
  localparam logic [7:0] CFG_MAX_RADIX = 8'd16;
  localparam logic [7:0] CFG_BAD_RADIX = 8'd1;

  typedef struct packed {
    logic      step;
    logic      clear;
    base_sel_t base_sel;
    logic      acc;
    logic      adv;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic is_blank;
    logic is_zero;
    logic is_x;
    logic digit_ok;
    logic ovf;
    logic cfg_invalid;
    logic cfg_zero;
    logic base_zero;
    logic over_set;
  } status_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
    logic        overflowed;
  } result_t;

  // Digit value of a character, or NO_DIGIT when it is not 0-9, a-f, A-F.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 8'd10;
    end else begin
      d = {3'b000, NO_DIGIT};
    end
    return d[4:0];
  endfunction

endpackage

FILE: rtl/t2u_in_if.sv
// Input character channel of the text to u64 parser: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps

interface t2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink (input valid, input ch, input first, output ready);
endinterface

FILE: rtl/t2u_out_if.sv
// Result channel of the text to u64 parser: valid/ready plus payload.
// No dependencies.
`timescale 1ns / 1ps

interface t2u_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] end_offset;
  logic        overflowed;

  modport source (output valid, output value, output end_offset, output overflowed,
                  input ready);
  modport sink (input valid, input value, input end_offset, input overflowed,
                output ready);
endinterface

FILE: rtl/text_to_u64_parser_core.sv
// Channel  | Dir | Handshake         | Payload
// in_if    | in  | valid/ready       | ch[7:0], first
// out_if   | out | valid/ready       | value[63:0], end_offset[15:0], overflowed
// cfg      | in  | cfg_wr_en, no ack | cfg_wr_data[7:0] = number base
//
// One character is taken per clock while in_if.ready is high; the radix multiply-add
// and its overflow check on the 64-bit accumulator complete in that same cycle. The
// result of the character ending a number is registered in the output register, or
// in the skid stage while that is held. in_if.ready drops only when both result stages are full.
// Synchronous reset leaves the parser waiting for a first character, base 0.
// Top level of the text to u64 parser. Depends on t2u_pkg, the channel
// interfaces, t2u_ctrl, t2u_dpath, t2u_outbuf and the assertion macro header.
`timescale 1ns / 1ps
`include "text_to_u64_parser_core_defines.svh"

module text_to_u64_parser_core #(
  parameter longint unsigned MAX_OFFSET = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  t2u_in_if.sink      in_if,
  t2u_out_if.source   out_if
);

  t2u_pkg::cmd_t    cmd;
  t2u_pkg::status_t status;
  t2u_pkg::result_t result;
  t2u_pkg::phase_t  phase;
  logic             can_push;
  logic             fire;
  logic             push;

  assign in_if.ready = can_push;
  assign fire        = in_if.valid && can_push;
  assign push        = cmd.step && cmd.emit;

  t2u_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .first  (in_if.first),
    .status (status),
    .cmd    (cmd),
    .phase  (phase)
  );

  t2u_dpath #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ch          (in_if.ch),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

  t2u_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .can_push  (can_push),
    .out_if    (out_if)
  );

  `T2U_ASSERT(a_stall_needs_result, !in_if.ready |-> out_if.valid, "input stalled with no result held")
  `T2U_ASSERT(a_skip_has_overflow, (phase == t2u_pkg::PH_SKIP) |-> status.over_set, "skipping digits without overflow")
  `T2U_ASSERT(a_overflow_saturates, (out_if.valid && out_if.overflowed) |-> (out_if.value == '1), "overflowed result not saturated")
  `T2U_ASSERT_NEXT(a_push_shows, push, out_if.valid, "emitted item did not reach the output")

endmodule

FILE: rtl/t2u_ctrl.sv
// Parser controller: phase state machine that turns character status into
// datapath commands. Depends on t2u_pkg.
`timescale 1ns / 1ps

module t2u_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              first,
  input  t2u_pkg::status_t  status,
  output t2u_pkg::cmd_t     cmd,
  output t2u_pkg::phase_t   phase
);

  t2u_pkg::phase_t state_r, state_nxt;
  t2u_pkg::phase_t cur;
  logic            bad_start;
  logic            base_is_zero;
  logic            to_digits;

  // A first character restarts the parse as if the phase were blank skipping.
  always_comb begin
    bad_start    = first && status.cfg_invalid;
    cur          = first ? t2u_pkg::PH_BLANK : state_r;
    base_is_zero = first ? status.cfg_zero : status.base_zero;
    to_digits    = 1'b0;
    unique case (cur)
      t2u_pkg::PH_BLANK:  to_digits = !status.is_blank && !(base_is_zero && status.is_zero);
      t2u_pkg::PH_ZERO:   to_digits = !status.is_x;
      t2u_pkg::PH_DIGITS: to_digits = 1'b1;
      default:            to_digits = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      if (bad_start) begin
        state_nxt = t2u_pkg::PH_DONE;
      end else begin
        state_nxt = cur;
        unique case (cur)
          t2u_pkg::PH_BLANK: begin
            if (!status.is_blank && base_is_zero && status.is_zero) begin
              state_nxt = t2u_pkg::PH_ZERO;
            end
          end
          t2u_pkg::PH_ZERO: begin
            if (status.is_x) begin
              state_nxt = t2u_pkg::PH_DIGITS;
            end
          end
          t2u_pkg::PH_SKIP: begin
            if (!status.digit_ok) begin
              state_nxt = t2u_pkg::PH_DONE;
            end
          end
          default: begin
          end
        endcase
        if (to_digits) begin
          if (!status.digit_ok) begin
            state_nxt = t2u_pkg::PH_DONE;
          end else if (status.ovf) begin
            state_nxt = t2u_pkg::PH_SKIP;
          end else begin
            state_nxt = t2u_pkg::PH_DIGITS;
          end
        end
      end
    end
  end

  always_comb begin
    cmd.step     = fire;
    cmd.clear    = first;
    cmd.base_sel = first ? t2u_pkg::BASE_CFG : t2u_pkg::BASE_KEEP;
    cmd.acc      = 1'b0;
    cmd.adv      = 1'b0;
    cmd.emit     = 1'b0;
    if (bad_start) begin
      cmd.base_sel = t2u_pkg::BASE_CLEAR;
      cmd.emit     = 1'b1;
    end else begin
      unique case (cur)
        t2u_pkg::PH_BLANK: begin
          if (status.is_blank) begin
            cmd.adv = 1'b1;
          end else if (base_is_zero && status.is_zero) begin
            cmd.adv = 1'b1;
          end else if (base_is_zero) begin
            cmd.base_sel = t2u_pkg::BASE_TEN;
          end
        end
        t2u_pkg::PH_ZERO: begin
          if (status.is_x) begin
            cmd.base_sel = t2u_pkg::BASE_HEX;
            cmd.adv      = 1'b1;
          end else begin
            cmd.base_sel = t2u_pkg::BASE_OCT;
          end
        end
        t2u_pkg::PH_SKIP: begin
          if (status.digit_ok) begin
            cmd.adv = 1'b1;
          end else begin
            cmd.emit = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (to_digits) begin
        if (status.digit_ok) begin
          cmd.acc = 1'b1;
          cmd.adv = 1'b1;
        end else begin
          cmd.emit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= t2u_pkg::PH_DONE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign phase = state_r;

endmodule

FILE: rtl/t2u_dpath.sv
// Parser datapath: radix register, accumulator with multiply-add and overflow
// detect, position counter and character decode. Depends on t2u_pkg.
`timescale 1ns / 1ps

module t2u_dpath #(
  parameter longint unsigned MAX_OFFSET = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic [7:0]        ch,
  input  t2u_pkg::cmd_t     cmd,
  output t2u_pkg::status_t  status,
  output t2u_pkg::result_t  result
);

  localparam logic [15:0] POS_CAP =
    (MAX_OFFSET < 64'd65535) ? MAX_OFFSET[15:0] : 16'hFFFF;

  logic [7:0]  cfg_base_r;
  logic [4:0]  base_r, base_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        any_r, any_nxt;
  logic        over_r, over_nxt;

  logic [4:0]  digit;
  logic [4:0]  eff_base;
  logic [63:0] eff_acc;
  logic [15:0] eff_pos;
  logic        eff_any;
  logic        eff_over;
  logic [68:0] prod;
  logic [64:0] sum;
  logic        ovf;

  assign digit = t2u_pkg::digit_of(ch);

  always_comb begin
    unique case (cmd.base_sel)
      t2u_pkg::BASE_KEEP:  eff_base = base_r;
      t2u_pkg::BASE_CFG:   eff_base = cfg_base_r[4:0];
      t2u_pkg::BASE_TEN:   eff_base = t2u_pkg::RADIX_DEC;
      t2u_pkg::BASE_OCT:   eff_base = t2u_pkg::RADIX_OCT;
      t2u_pkg::BASE_HEX:   eff_base = t2u_pkg::RADIX_HEX;
      default:             eff_base = 5'd0;
    endcase
  end

  assign eff_acc  = cmd.clear ? 64'd0 : accum_r;
  assign eff_pos  = cmd.clear ? 16'd0 : pos_r;
  assign eff_any  = cmd.clear ? 1'b0 : any_r;
  assign eff_over = cmd.clear ? 1'b0 : over_r;

  // The radix is at most 16, so overflow shows in the top five product bits
  // or in the carry out of adding the digit.
  assign prod = {5'd0, eff_acc} * {64'd0, eff_base};
  assign sum  = {1'b0, prod[63:0]} + {60'd0, digit};
  assign ovf  = (|prod[68:64]) | sum[64];

  always_comb begin
    status.is_blank    = (ch == t2u_pkg::CH_SPACE) || (ch == t2u_pkg::CH_TAB) ||
                         (ch == t2u_pkg::CH_LF) || (ch == t2u_pkg::CH_CR);
    status.is_zero     = (ch == t2u_pkg::CH_0);
    status.is_x        = (ch == t2u_pkg::CH_LO_X) || (ch == t2u_pkg::CH_UP_X);
    status.digit_ok    = digit < eff_base;
    status.ovf         = ovf;
    status.cfg_invalid = (cfg_base_r == t2u_pkg::CFG_BAD_RADIX) ||
                         (cfg_base_r > t2u_pkg::CFG_MAX_RADIX);
    status.cfg_zero    = (cfg_base_r == 8'd0);
    status.base_zero   = (base_r == 5'd0);
    status.over_set    = over_r;
  end

  always_comb begin
    result.value      = eff_acc;
    result.end_offset = (eff_any || eff_over) ? eff_pos : 16'd0;
    result.overflowed = eff_over;
  end

  always_comb begin
    base_nxt  = eff_base;
    accum_nxt = eff_acc;
    any_nxt   = eff_any;
    over_nxt  = eff_over;
    pos_nxt   = eff_pos;
    if (cmd.acc) begin
      if (ovf) begin
        accum_nxt = '1;
        over_nxt  = 1'b1;
      end else begin
        accum_nxt = sum[63:0];
        any_nxt   = 1'b1;
      end
    end
    if (cmd.adv && (eff_pos < POS_CAP)) begin
      pos_nxt = eff_pos + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= 8'd0;
      base_r     <= 5'd0;
      accum_r    <= 64'd0;
      pos_r      <= 16'd0;
      any_r      <= 1'b0;
      over_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_base_r <= cfg_wr_data;
      end
      if (cmd.step) begin
        base_r  <= base_nxt;
        accum_r <= accum_nxt;
        pos_r   <= pos_nxt;
        any_r   <= any_nxt;
        over_r  <= over_nxt;
      end
    end
  end

endmodule

FILE: rtl/t2u_outbuf.sv
// Two-entry result buffer: output register plus skid stage, so the input
// side keeps moving while a result waits. Depends on t2u_pkg and t2u_out_if.
`timescale 1ns / 1ps

module t2u_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  t2u_pkg::result_t  push_data,
  output logic              can_push,
  t2u_out_if.source         out_if
);

  t2u_pkg::result_t main_r, main_nxt;
  t2u_pkg::result_t skid_r, skid_nxt;
  logic             main_v_r, main_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic             pop;

  assign pop      = main_v_r && out_if.ready;
  assign can_push = !skid_v_r;

  // The skid stage only fills while the output register is held.
  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_if.valid      = main_v_r;
  assign out_if.value      = main_r.value;
  assign out_if.end_offset = main_r.end_offset;
  assign out_if.overflowed = main_r.overflowed;

endmodule
